/* hdl/lpc_pkg.sv */
`default_nettype none

package lpc_pkg;

  // Sizes of the layer store
  localparam int unsigned LED_NUM   = 2;
  localparam int unsigned LAYER_NUM = 4;
  localparam int unsigned ENTRY_NUM = LED_NUM * LAYER_NUM;
  localparam int unsigned ENTRY_W   = (ENTRY_NUM > 1) ? $clog2(ENTRY_NUM) : 1;

  // Field widths
  localparam int unsigned COLOUR_W  = 25;
  localparam int unsigned PATTERN_W = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned DUTY_W    = 9;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned BLANK_W   = 32;

  // Output duty channels: three per LED, two LED slots on the ports
  localparam int unsigned DUTY_NUM  = 6;

  localparam logic [COLOUR_W-1:0]  COLOUR_TRANSP = 25'h100_0000;
  localparam int unsigned          TRANSP_BIT    = 24;
  localparam logic [PATTERN_W-1:0] POS_WRAP      = 32'h8000_0000;
  localparam logic [DUTY_W-1:0]    DUTY_FULL     = 9'd256;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_BLANK = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic apply;
    logic compose;
    logic capture;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic produce;
  } dp_status_t;

endpackage : lpc_pkg

`default_nettype wire

/* hdl/lpc_ctrl.sv */
`default_nettype none

module lpc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  lpc_pkg::dp_status_t  status_i,
  output lpc_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy_o,
  output logic                 valid_o
);
  import lpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_APPLY   = 3'b010,
    ST_COMPOSE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // Sequence one request: latch, update state, composite
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_COMPOSE;
      end
      ST_COMPOSE: begin
        cmd_o.compose = 1'b1;
        cmd_o.capture = status_i.produce;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign valid_d = cmd_o.capture;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;

  // A result strobe only follows a compositing cycle
  a_valid_after_compose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_COMPOSE))
    else $error("result strobe without compositing cycle");

  // An accepted request moves on to the update step
  a_accept_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_APPLY))
    else $error("accepted request did not enter update step");

  a_apply_to_compose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (state_q == ST_COMPOSE))
    else $error("update step not followed by compositing");

  a_compose_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPOSE) |=> (state_q == ST_IDLE))
    else $error("compositing not followed by idle");

endmodule : lpc_ctrl

`default_nettype wire

/* hdl/lpc_datapath.sv */
`default_nettype none

module lpc_datapath (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  lpc_pkg::ctrl_cmd_t                      cmd_i,
  output lpc_pkg::dp_status_t                     status_o,
  input  wire [1:0]                               mode_i,
  input  wire                                     led_index_i,
  input  wire [1:0]                               layer_index_i,
  input  wire [lpc_pkg::COLOUR_W-1:0]             colour_first_i,
  input  wire [lpc_pkg::COLOUR_W-1:0]             colour_second_i,
  input  wire [lpc_pkg::PATTERN_W-1:0]            blink_pattern_i,
  input  wire [lpc_pkg::COUNT_W-1:0]              flash_count_i,
  input  wire [lpc_pkg::BLANK_W-1:0]              blank_us_i,
  input  wire [lpc_pkg::TIME_W-1:0]               now_us_i,
  output logic [lpc_pkg::DUTY_NUM-1:0][lpc_pkg::DUTY_W-1:0] duty_o
);
  import lpc_pkg::*;

  // Latched request
  mode_e                mode_q;
  logic                 led_q;
  logic [1:0]           layer_q;
  logic [COLOUR_W-1:0]  c1_q, c2_q;
  logic [PATTERN_W-1:0] pat_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [BLANK_W-1:0]   bus_q;
  logic [TIME_W-1:0]    now_q;

  // Layer store and global state
  logic [ENTRY_NUM-1:0][PATTERN_W-1:0] pattern_q;
  logic [ENTRY_NUM-1:0][COLOUR_W-1:0]  first_q, second_q;
  logic [ENTRY_NUM-1:0][COUNT_W-1:0]   countdown_q;
  logic [PATTERN_W-1:0]                onehot_q;
  logic [POS_W-1:0]                    posnum_q;
  logic [TIME_W-1:0]                   deadline_q;
  logic                                started_q;
  logic                                item_ok_q;

  logic [DUTY_NUM-1:0][DUTY_W-1:0] duty_q, duty_d;

  logic                 in_range;
  logic [ENTRY_W-1:0]   set_idx;
  logic [PATTERN_W-1:0] set_pat;
  logic [PATTERN_W-1:0] shifted;

  // Hold the request while it is worked on
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      led_q   <= led_index_i;
      layer_q <= layer_index_i;
      c1_q    <= colour_first_i;
      c2_q    <= colour_second_i;
      pat_q   <= blink_pattern_i;
      cnt_q   <= flash_count_i;
      bus_q   <= blank_us_i;
      now_q   <= now_us_i;
    end
  end

  // Decode the addressed entry and align a flash pattern to the position
  assign in_range = (32'(led_q) < LED_NUM) && (32'(layer_q) < LAYER_NUM);
  assign set_idx  = ENTRY_W'(ENTRY_W'(led_q) * ENTRY_W'(LAYER_NUM) + ENTRY_W'(layer_q));
  assign shifted  = PATTERN_W'({pat_q, pat_q} >> posnum_q);
  assign set_pat  = (cnt_q != '0) ? shifted : pat_q;

  // Update state on the apply step, count down flash layers after a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_NUM; i++) begin
        pattern_q[i]   <= '0;
        first_q[i]     <= COLOUR_TRANSP;
        second_q[i]    <= COLOUR_TRANSP;
        countdown_q[i] <= '0;
      end
      onehot_q   <= PATTERN_W'(1);
      posnum_q   <= '0;
      deadline_q <= '0;
      started_q  <= 1'b0;
      item_ok_q  <= 1'b0;
    end else if (cmd_i.apply) begin
      item_ok_q <= (mode_q != MODE_SET) || in_range;
      unique case (mode_q)
        MODE_INIT: begin
          for (int i = 0; i < ENTRY_NUM; i++) begin
            first_q[i]  <= COLOUR_TRANSP;
            second_q[i] <= COLOUR_TRANSP;
          end
          started_q <= 1'b1;
        end
        MODE_SET: begin
          if (in_range) begin
            pattern_q[set_idx]   <= set_pat;
            first_q[set_idx]     <= c1_q;
            second_q[set_idx]    <= c2_q;
            countdown_q[set_idx] <= cnt_q;
          end
        end
        MODE_BLANK: begin
          deadline_q <= now_q + TIME_W'(bus_q);
        end
        MODE_TICK: begin
          if ((onehot_q >> 1) == '0) begin
            onehot_q <= POS_WRAP;
            posnum_q <= '0;
          end else begin
            onehot_q <= onehot_q >> 1;
            posnum_q <= posnum_q + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.compose && (mode_q == MODE_TICK)) begin
      for (int i = 0; i < ENTRY_NUM; i++) begin
        if (countdown_q[i] != '0) begin
          countdown_q[i] <= countdown_q[i] - COUNT_W'(1);
          if (countdown_q[i] == COUNT_W'(1)) begin
            first_q[i]  <= COLOUR_TRANSP;
            second_q[i] <= COLOUR_TRANSP;
          end
        end
      end
    end
  end

  // Composite each LED: first opaque layer wins, black when none or blanked
  always_comb begin
    logic [COLOUR_W-1:0] pick;
    logic [COLOUR_W-1:0] rgba;
    logic                found;
    logic                blanked;
    blanked = (now_q < deadline_q);
    duty_d  = '0;
    for (int l = 0; l < 2; l++) begin
      rgba  = '0;
      found = 1'b0;
      if (l < LED_NUM) begin
        for (int e = 0; e < LAYER_NUM; e++) begin
          pick = ((pattern_q[l*LAYER_NUM+e] & onehot_q) != '0) ?
                 second_q[l*LAYER_NUM+e] : first_q[l*LAYER_NUM+e];
          if (!found && !pick[TRANSP_BIT]) begin
            rgba  = pick;
            found = 1'b1;
          end
        end
      end
      if (!found || blanked) begin
        rgba = '0;
      end
      duty_d[3*l]   = DUTY_FULL - DUTY_W'(rgba[23:16]);
      duty_d[3*l+1] = DUTY_FULL - DUTY_W'(rgba[15:8]);
      duty_d[3*l+2] = DUTY_FULL - DUTY_W'(rgba[7:0]);
    end
  end

  // Register the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      duty_q <= duty_d;
    end
  end

  assign status_o.produce = started_q && item_ok_q;
  assign duty_o           = duty_q;

endmodule : lpc_datapath

`default_nettype wire

/* hdl/layered_led_pattern_compositor_unit.sv */
// Layered LED pattern compositor: two RGB LEDs, four priority layers each.
//
// Request channel: present mode_i and its fields with start_i high while
// busy_o is low; the request is taken at that clock edge. Every request
// carries now_us_i. Set requests address a layer with led_index_i and
// layer_index_i; blank requests use blank_us_i; tick requests advance the
// blink position and count down flash layers.
//
// Result channel: valid_o is high for exactly one cycle while the six duty
// ports hold the composited output. The receiver cannot stall; a result
// must be taken in its strobe cycle. Requests before the first init, and
// set requests that address no layer, give no result.
//
// Sequence: a request passes through latch, state update and compositing,
// and busy_o stays high during state update and compositing. The result
// strobe comes in the cycle after compositing, when the next request may
// already be accepted; a new request is not taken while busy_o is high. The
// compositing step walks the layers in one combinational pass.
//
// Reset: all layers transparent, position at bit zero, not started.
`default_nettype none

module layered_led_pattern_compositor_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire [1:0]                          mode_i,
  input  wire                                led_index_i,
  input  wire [1:0]                          layer_index_i,
  input  wire [lpc_pkg::COLOUR_W-1:0]        colour_first_i,
  input  wire [lpc_pkg::COLOUR_W-1:0]        colour_second_i,
  input  wire [lpc_pkg::PATTERN_W-1:0]       blink_pattern_i,
  input  wire [lpc_pkg::COUNT_W-1:0]         flash_count_i,
  input  wire [lpc_pkg::BLANK_W-1:0]         blank_us_i,
  input  wire [lpc_pkg::TIME_W-1:0]          now_us_i,
  output logic                               valid_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_red_a_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_green_a_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_blue_a_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_red_b_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_green_b_o,
  output logic [lpc_pkg::DUTY_W-1:0]         duty_blue_b_o
);
  import lpc_pkg::*;

  ctrl_cmd_t                       cmd;
  dp_status_t                      status;
  logic [DUTY_NUM-1:0][DUTY_W-1:0] duty;

  lpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  lpc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_i),
    .led_index_i     (led_index_i),
    .layer_index_i   (layer_index_i),
    .colour_first_i  (colour_first_i),
    .colour_second_i (colour_second_i),
    .blink_pattern_i (blink_pattern_i),
    .flash_count_i   (flash_count_i),
    .blank_us_i      (blank_us_i),
    .now_us_i        (now_us_i),
    .duty_o          (duty)
  );

  assign duty_red_a_o   = duty[0];
  assign duty_green_a_o = duty[1];
  assign duty_blue_a_o  = duty[2];
  assign duty_red_b_o   = duty[3];
  assign duty_green_b_o = duty[4];
  assign duty_blue_b_o  = duty[5];

endmodule : layered_led_pattern_compositor_unit

`default_nettype wire

/* tb/tb_layered_led_pattern_compositor_unit.sv */
`timescale 1ns / 100ps

module tb_layered_led_pattern_compositor_unit;
  import lpc_pkg::*;

  // One duty frame: index 0..2 red/green/blue of LED a, 3..5 of LED b
  typedef logic [DUTY_NUM-1:0][DUTY_W-1:0] duty_frame_t;

  typedef struct {
    mode_e                mode;
    logic                 led;
    logic [1:0]           layer;
    logic [COLOUR_W-1:0]  colour_first;
    logic [COLOUR_W-1:0]  colour_second;
    logic [PATTERN_W-1:0] pattern;
    logic [COUNT_W-1:0]   count;
    logic [BLANK_W-1:0]   blank_us;
    logic [TIME_W-1:0]    now_us;
  } lpc_req_t;

  // Layer compositor model plus the queue of duty frames still to come
  class led_scoreboard;
    logic [PATTERN_W-1:0] blink_mem  [LED_NUM][LAYER_NUM];
    logic [COLOUR_W-1:0]  first_mem  [LED_NUM][LAYER_NUM];
    logic [COLOUR_W-1:0]  second_mem [LED_NUM][LAYER_NUM];
    logic [COUNT_W-1:0]   flash_mem  [LED_NUM][LAYER_NUM];
    logic [PATTERN_W-1:0] pos_onehot;
    logic [POS_W-1:0]     pos_number;
    logic [TIME_W-1:0]    blank_deadline;
    logic                 started;
    duty_frame_t          pending[$];
    int unsigned          errors;

    function new();
      for (int led = 0; led < LED_NUM; led++) begin
        for (int lay = 0; lay < LAYER_NUM; lay++) begin
          blink_mem[led][lay]  = '0;
          first_mem[led][lay]  = COLOUR_TRANSP;
          second_mem[led][lay] = COLOUR_TRANSP;
          flash_mem[led][lay]  = '0;
        end
      end
      pos_onehot     = 32'h1;
      pos_number     = '0;
      blank_deadline = '0;
      started        = 1'b0;
      errors         = 0;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Take the first opaque layer per LED; black when none or while blanked
    function duty_frame_t compose_frame(logic [TIME_W-1:0] now);
      duty_frame_t         frame;
      logic [COLOUR_W-1:0] pick;
      logic                found;
      for (int i = 0; i < DUTY_NUM; i++) frame[i] = DUTY_FULL;
      for (int led = 0; led < LED_NUM; led++) begin
        pick  = COLOUR_TRANSP;
        found = 1'b0;
        for (int lay = 0; lay < LAYER_NUM; lay++) begin
          if (!found) begin
            pick  = ((blink_mem[led][lay] & pos_onehot) != '0) ? second_mem[led][lay]
                                                                : first_mem[led][lay];
            found = !pick[TRANSP_BIT];
          end
        end
        if (!found || now < blank_deadline) pick = '0;
        for (int ch = 0; ch < 3; ch++)
          frame[3*led + ch] = DUTY_FULL - {1'b0, pick[16 - 8*ch +: 8]};
      end
      return frame;
    endfunction

    // Apply one accepted request and queue the frame it produces, if any
    function void note_request(lpc_req_t r);
      logic [PATTERN_W-1:0] pat;
      logic [POS_W-1:0]     shift;
      case (r.mode)
        MODE_INIT: begin
          for (int led = 0; led < LED_NUM; led++) begin
            for (int lay = 0; lay < LAYER_NUM; lay++) begin
              first_mem[led][lay]  = COLOUR_TRANSP;
              second_mem[led][lay] = COLOUR_TRANSP;
            end
          end
          started = 1'b1;
          pending.push_back(compose_frame(r.now_us));
        end
        MODE_SET: begin
          // Flash layers line their pattern up with the current position
          pat   = r.pattern;
          shift = pos_number;
          if (r.count != '0 && shift != '0) pat = (pat >> shift) | (pat << (32 - shift));
          blink_mem[r.led][r.layer]  = pat;
          first_mem[r.led][r.layer]  = r.colour_first;
          second_mem[r.led][r.layer] = r.colour_second;
          flash_mem[r.led][r.layer]  = r.count;
          if (started) pending.push_back(compose_frame(r.now_us));
        end
        MODE_BLANK: begin
          blank_deadline = r.now_us + {32'b0, r.blank_us};
          if (started) pending.push_back(compose_frame(r.now_us));
        end
        default: begin
          pos_onehot = pos_onehot >> 1;
          pos_number = pos_number + 1'b1;
          if (pos_onehot == '0) begin
            pos_onehot = POS_WRAP;
            pos_number = '0;
          end
          if (started) pending.push_back(compose_frame(r.now_us));
          // Count down flash layers; drop expired ones to transparent
          for (int led = 0; led < LED_NUM; led++) begin
            for (int lay = 0; lay < LAYER_NUM; lay++) begin
              if (flash_mem[led][lay] != '0) begin
                flash_mem[led][lay] = flash_mem[led][lay] - 1'b1;
                if (flash_mem[led][lay] == '0) begin
                  first_mem[led][lay]  = COLOUR_TRANSP;
                  second_mem[led][lay] = COLOUR_TRANSP;
                end
              end
            end
          end
        end
      endcase
    endfunction

    function void check_frame(duty_frame_t got);
      duty_frame_t want;
      logic        bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected result at %0t: a %0d %0d %0d b %0d %0d %0d", $realtime,
                   got[0], got[1], got[2], got[3], got[4], got[5]);
        return;
      end
      want = pending.pop_front();
      bad  = 1'b0;
      for (int i = 0; i < DUTY_NUM; i++)
        if (got[i] !== want[i]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("tb: mismatch at %0t: exp a %0d %0d %0d b %0d %0d %0d, got a %0d %0d %0d b %0d %0d %0d",
                   $realtime, want[0], want[1], want[2], want[3], want[4], want[5],
                   got[0], got[1], got[2], got[3], got[4], got[5]);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [1:0]           mode_i;
  logic                 led_index_i;
  logic [1:0]           layer_index_i;
  logic [COLOUR_W-1:0]  colour_first_i;
  logic [COLOUR_W-1:0]  colour_second_i;
  logic [PATTERN_W-1:0] blink_pattern_i;
  logic [COUNT_W-1:0]   flash_count_i;
  logic [BLANK_W-1:0]   blank_us_i;
  logic [TIME_W-1:0]    now_us_i;
  logic                 valid_o;
  logic [DUTY_W-1:0]    duty_red_a_o;
  logic [DUTY_W-1:0]    duty_green_a_o;
  logic [DUTY_W-1:0]    duty_blue_a_o;
  logic [DUTY_W-1:0]    duty_red_b_o;
  logic [DUTY_W-1:0]    duty_green_b_o;
  logic [DUTY_W-1:0]    duty_blue_b_o;

  led_scoreboard        sb;
  logic [TIME_W-1:0]    clock_us;

  layered_led_pattern_compositor_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Check every strobed frame against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1)
      sb.check_frame({duty_blue_b_o, duty_green_b_o, duty_red_b_o,
                      duty_blue_a_o, duty_green_a_o, duty_red_a_o});
  end

  function automatic lpc_req_t make_req(mode_e m, logic led, logic [1:0] lay,
                                        logic [COLOUR_W-1:0] c1, logic [COLOUR_W-1:0] c2,
                                        logic [PATTERN_W-1:0] pat, logic [COUNT_W-1:0] cnt,
                                        logic [BLANK_W-1:0] bus, logic [TIME_W-1:0] now);
    lpc_req_t r;
    r.mode          = m;
    r.led           = led;
    r.layer         = lay;
    r.colour_first  = c1;
    r.colour_second = c2;
    r.pattern       = pat;
    r.count         = cnt;
    r.blank_us      = bus;
    r.now_us        = now;
    return r;
  endfunction

  // Mostly set and tick traffic on a slowly advancing clock, with rare jumps
  function automatic lpc_req_t rand_req();
    lpc_req_t    r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)       r.mode = MODE_INIT;
    else if (roll < 48) r.mode = MODE_SET;
    else if (roll < 58) r.mode = MODE_BLANK;
    else                r.mode = MODE_TICK;
    r.led           = 1'($urandom_range(0, 1));
    r.layer         = 2'($urandom_range(0, 3));
    r.colour_first  = COLOUR_W'($urandom);
    r.colour_first[TRANSP_BIT]  = ($urandom_range(0, 3) == 0);
    r.colour_second = COLOUR_W'($urandom);
    r.colour_second[TRANSP_BIT] = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0:       r.pattern = '0;
      1:       r.pattern = '1;
      default: r.pattern = $urandom;
    endcase
    roll = $urandom_range(0, 19);
    if (roll < 10)      r.count = '0;
    else if (roll < 17) r.count = COUNT_W'($urandom_range(1, 6));
    else                r.count = COUNT_W'($urandom);
    r.blank_us = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
    if ($urandom_range(0, 24) == 0) clock_us = {$urandom, $urandom};
    else                            clock_us = clock_us + TIME_W'($urandom_range(0, 60));
    r.now_us = clock_us;
    return r;
  endfunction

  // Present a request and hold it until the block takes it
  task automatic send_req(input lpc_req_t r);
    @(negedge clk_i);
    start_i         <= 1'b1;
    mode_i          <= r.mode;
    led_index_i     <= r.led;
    layer_index_i   <= r.layer;
    colour_first_i  <= r.colour_first;
    colour_second_i <= r.colour_second;
    blink_pattern_i <= r.pattern;
    flash_count_i   <= r.count;
    blank_us_i      <= r.blank_us;
    now_us_i        <= r.now_us;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(r);
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Stop sending until every predicted frame has come out
  task automatic drain();
    while (sb.outstanding() != 0) hold_off(1);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned waited;
    sb              = new();
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = MODE_INIT;
    led_index_i     = 1'b0;
    layer_index_i   = '0;
    colour_first_i  = '0;
    colour_second_i = '0;
    blink_pattern_i = '0;
    flash_count_i   = '0;
    blank_us_i      = '0;
    now_us_i        = '0;
    clock_us        = 64'd100_000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Before the first init: state moves, nothing comes out
    send_req(make_req(MODE_SET, 1'b0, 2'd0, 25'h0_123456, 25'h0_abcdef, 32'haaaa_aaaa,
                      16'd0, 32'd0, 64'd1000));
    send_req(make_req(MODE_BLANK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd50, 64'd1100));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd1200));
    // Init clears colours but keeps patterns
    send_req(make_req(MODE_INIT, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd1300));
    // Colour extremes, transparent fall-through, full pattern
    send_req(make_req(MODE_SET, 1'b0, 2'd3, 25'h0_000000, 25'h0_ffffff, 32'hffff_ffff,
                      16'd0, 32'd0, 64'd1400));
    send_req(make_req(MODE_SET, 1'b1, 2'd0, 25'h1_ffffff, 25'h1_000000, 32'h0000_0000,
                      16'd0, 32'd0, 64'd1500));
    send_req(make_req(MODE_SET, 1'b1, 2'd2, 25'h0_00ff00, 25'h0_ff00ff, 32'h5555_5555,
                      16'd0, 32'd0, 64'd1600));
    // Flash layer set at a nonzero position gets its pattern rotated
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd1700));
    send_req(make_req(MODE_SET, 1'b0, 2'd0, 25'h0_0000ff, 25'h0_ff0000, 32'h0000_0001,
                      16'd3, 32'd0, 64'd1800));
    // Three ticks expire the flash layer
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd1900));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd2000));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd2100));
    // Deadline wraps past the top of the time range
    send_req(make_req(MODE_BLANK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'hffff_ffff,
                      64'hffff_ffff_ffff_ff00));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, '1));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd0));
    send_req(make_req(MODE_BLANK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd0));
    send_req(make_req(MODE_SET, 1'b1, 2'd3, 25'h0_c0ffee, 25'h0_3a5c7e, 32'h8000_0001,
                      16'hffff, 32'd0, 64'd10));
    send_req(make_req(MODE_SET, 1'b0, 2'd1, 25'h0_808080, 25'h0_7f7f7f, 32'hf0f0_f0f0,
                      16'd1, 32'd0, 64'd20));
    send_req(make_req(MODE_TICK, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd30));
    send_req(make_req(MODE_INIT, 1'b0, 2'd0, '0, '0, '0, 16'd0, 32'd0, 64'd40));
    drain();

    // Random traffic in bursts with random gaps between them
    burst_left = 0;
    for (int n = 0; n < 1600; n++) begin
      if (n % 500 == 499) drain();
      if (burst_left == 0) begin
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
      send_req(rand_req());
      burst_left--;
    end
    hold_off(1);

    // Let the last frames out, then wait before the final check
    waited = 0;
    while (sb.outstanding() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
